FILE: hdl/sem_pkg.sv
`default_nettype none
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int PIX_W          = 8;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int ROOT_W         = 12;
    localparam int SUM_W          = 21;
    localparam int GRAD_W         = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_SQUARE = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic clr;
        logic accept;
        logic load;
        logic square;
        logic root_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic emit;
        logic root_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: hdl/sem_controller.sv
`default_nettype none
module sem_controller
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  sem_pkg::sts_t      sts,
    output sem_pkg::cmd_t      cmd
);

    sem_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sem_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            sem_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sem_pkg::ST_LOAD;
                end
            end
            sem_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sts.emit ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
            end
            sem_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                begin
                    state_next = sem_pkg::ST_FINISH;
                end
            end
            sem_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/sem_datapath.sv
`default_nettype none
module sem_datapath
#(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  sem_pkg::cmd_t                       cmd,
    output sem_pkg::sts_t                       sts,
    input  wire logic                           cfg_valid,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           command,
    input  wire logic [sem_pkg::PIX_W-1:0]      red_in,
    input  wire logic [sem_pkg::PIX_W-1:0]      green_in,
    input  wire logic [sem_pkg::PIX_W-1:0]      blue_in,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [sem_pkg::PIX_W-1:0]           red_edge,
    output logic [sem_pkg::PIX_W-1:0]           green_edge,
    output logic [sem_pkg::PIX_W-1:0]           blue_edge,
    output logic                                frame_end
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int IRW = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RGB = sem_pkg::RGB_W;
    localparam int PW  = sem_pkg::PIX_W;
    localparam int RW  = sem_pkg::ROOT_W;
    localparam int SW  = sem_pkg::SUM_W;
    localparam int GW  = sem_pkg::GRAD_W;

    // configuration
    logic [sem_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [sem_pkg::HEIGHT_W-1:0] image_height_reg;
    logic [WDW-1:0] wd;
    logic [HDW-1:0] ht;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sem_pkg::WIDTH_W'(1024);
            image_height_reg <= sem_pkg::HEIGHT_W'(768);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sem_pkg::REG_WIDTH:  image_width_reg  <= cfg_data[sem_pkg::WIDTH_W-1:0];
                sem_pkg::REG_HEIGHT: image_height_reg <= cfg_data[sem_pkg::HEIGHT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
            wd = WDW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            wd = WDW'(MAX_WIDTH);
        else
            wd = WDW'(image_width_reg);
        if (image_height_reg == '0)
            ht = HDW'(1);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            ht = HDW'(MAX_HEIGHT);
        else
            ht = HDW'(image_height_reg);
    end

    // input position and item latch
    logic [AW-1:0]  in_col_reg, in_col_next;
    logic [IRW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]  ic_reg, ic;
    logic [IRW-1:0] ir_reg, ir;
    logic [RGB-1:0] px_reg, px;
    logic           restart_reg, restart;
    logic [AW:0]    col_inc;

    always_comb
    begin
        restart = (32'(in_col_reg) >= 32'(wd)) || (32'(in_row_reg) > 32'(ht) + 1) ||
                  ((32'(in_row_reg) == 32'(ht) + 1) && (in_col_reg != '0));
        ic = restart ? '0 : in_col_reg;
        ir = restart ? '0 : in_row_reg;
        px = '0;
        if (command == sem_pkg::CMD_PIXEL && 32'(ir) < 32'(ht))
            px = {red_in, green_in, blue_in};
        col_inc     = {1'b0, ic} + (AW+1)'(1);
        in_col_next = AW'(col_inc);
        in_row_next = ir;
        if (32'(ir) == 32'(ht) + 1)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (32'(col_inc) >= 32'(wd))
        begin
            in_col_next = '0;
            in_row_next = ir + IRW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ic_reg      <= ic;
            ir_reg      <= ir;
            px_reg      <= px;
            restart_reg <= restart;
        end
    end

    // row stores: {older, newer} per column
    logic [2*RGB-1:0] row_mem [MAX_WIDTH];
    logic [2*RGB-1:0] rd_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             in_frame;
    logic             mem_we;

    assign in_frame = 32'(ir_reg) <= 32'(ht);
    assign mem_we   = cmd.load && in_frame;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_reg <= row_mem[ic];
        if (cmd.clr)
            row_mem[clr_cnt_reg] <= '0;
        else if (mem_we)
            row_mem[ic_reg] <= {rd_reg[RGB-1:0], px_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end

    // window and gradients
    logic [RGB-1:0] win_reg [3][3];
    logic [RGB-1:0] win_next [3][3];
    logic [RGB-1:0] wb [3][3];
    logic [RGB-1:0] ew [3][3];
    logic [RGB-1:0] newc [3];
    logic           last_row, emit;
    logic signed [GW-1:0] gx_next [3], gy_next [3];
    logic signed [GW-1:0] gx_reg [3], gy_reg [3];

    function automatic logic signed [GW-1:0] pix(input logic [RGB-1:0] w, input int c);
        pix = GW'(w[PW*(2-c) +: PW]);
    endfunction

    assign last_row = 32'(ir_reg) == 32'(ht) + 1;
    assign emit     = (ic_reg == '0) ? (32'(ir_reg) >= 2) : (ir_reg != '0);

    always_comb
    begin
        newc[0] = (in_frame && 32'(ir_reg) >= 2) ? rd_reg[2*RGB-1:RGB] : '0;
        newc[1] = (in_frame && ir_reg != '0) ? rd_reg[RGB-1:0] : '0;
        newc[2] = px_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                wb[i][j] = restart_reg ? '0 : win_reg[i][j];
            if (ic_reg == '0)
            begin
                ew[i][0]       = wb[i][1];
                ew[i][1]       = wb[i][2];
                ew[i][2]       = '0;
                win_next[i][0] = '0;
                win_next[i][1] = '0;
                win_next[i][2] = newc[i];
            end
            else
            begin
                win_next[i][0] = wb[i][1];
                win_next[i][1] = wb[i][2];
                win_next[i][2] = newc[i];
                ew[i][0]       = wb[i][1];
                ew[i][1]       = wb[i][2];
                ew[i][2]       = newc[i];
            end
            if (last_row)
            begin
                for (int j = 0; j < 3; j++)
                    win_next[i][j] = '0;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            gx_next[c] = (pix(ew[0][2], c) - pix(ew[0][0], c)) +
                         ((pix(ew[1][2], c) - pix(ew[1][0], c)) <<< 1) +
                         (pix(ew[2][2], c) - pix(ew[2][0], c));
            gy_next[c] = (pix(ew[2][0], c) - pix(ew[0][0], c)) +
                         ((pix(ew[2][1], c) - pix(ew[0][1], c)) <<< 1) +
                         (pix(ew[2][2], c) - pix(ew[0][2], c));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= win_next[i][j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                gx_reg[c] <= gx_next[c];
                gy_reg[c] <= gy_next[c];
            end
        end
    end

    // output position
    logic [AW-1:0]  out_col_reg, out_col_next, bcol;
    logic [ORW-1:0] out_row_reg, out_row_next, brow;
    logic [AW:0]    ocol_inc;
    logic [ORW:0]   orow_inc;
    logic           fe_next, fe_reg;

    always_comb
    begin
        bcol         = restart_reg ? '0 : out_col_reg;
        brow         = restart_reg ? '0 : out_row_reg;
        fe_next      = (32'(brow) == 32'(ht) - 1) && (32'(bcol) == 32'(wd) - 1);
        ocol_inc     = {1'b0, bcol} + (AW+1)'(1);
        orow_inc     = {1'b0, brow} + (ORW+1)'(1);
        out_col_next = bcol;
        out_row_next = brow;
        if (emit)
        begin
            out_col_next = AW'(ocol_inc);
            if (32'(ocol_inc) >= 32'(wd))
            begin
                out_col_next = '0;
                out_row_next = (32'(orow_inc) >= 32'(ht)) ? '0 : ORW'(orow_inc);
            end
        end
        if (last_row)
        begin
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cmd.load)
        begin
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            fe_reg <= fe_next;
    end

    // squares and bit-serial root, one lane per channel
    logic [SW-1:0]    s_reg [3];
    logic [RW-1:0]    r_reg [3];
    logic [RW-1:0]    bit_reg;
    logic [RW-1:0]    t [3];
    logic [2*RW-1:0]  tt [3];
    logic signed [2*GW-1:0] sqx [3], sqy [3];
    logic [2*GW-1:0]  ssum [3];
    logic [2*RW:0]    rr [3];
    logic [RW:0]      rnd [3];
    logic [PW-1:0]    mag [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sqx[c]  = gx_reg[c] * gx_reg[c];
            sqy[c]  = gy_reg[c] * gy_reg[c];
            ssum[c] = (2*GW)'(sqx[c]) + (2*GW)'(sqy[c]);
            t[c]    = r_reg[c] | bit_reg;
            tt[c]   = t[c] * t[c];
            rr[c]   = (2*RW+1)'(r_reg[c] * r_reg[c]) + (2*RW+1)'(r_reg[c]);
            rnd[c]  = {1'b0, r_reg[c]} +
                      (RW+1)'((2*RW+1)'(s_reg[c]) > rr[c]);
            mag[c]  = (rnd[c] > (RW+1)'(255)) ? PW'(255) : PW'(rnd[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            bit_reg <= {1'b1, {(RW-1){1'b0}}};
            for (int c = 0; c < 3; c++)
            begin
                s_reg[c] <= SW'(ssum[c]);
                r_reg[c] <= '0;
            end
        end
        else if (cmd.root_step)
        begin
            bit_reg <= bit_reg >> 1;
            for (int c = 0; c < 3; c++)
                if (tt[c] <= (2*RW)'(s_reg[c]))
                    r_reg[c] <= t[c];
        end
    end

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] red_reg, green_reg, blue_reg;
    logic          frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            red_reg       <= mag[0];
            green_reg     <= mag[1];
            blue_reg      <= mag[2];
            frame_end_reg <= fe_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_edge   = red_reg;
    assign green_edge = green_reg;
    assign blue_edge  = blue_reg;
    assign frame_end  = frame_end_reg;

    assign sts.clr_last  = clr_cnt_reg == AW'(MAX_WIDTH - 1);
    assign sts.emit      = emit;
    assign sts.root_last = bit_reg[0];
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

FILE: hdl/sobel_edge_magnitude_rgb.sv
`default_nettype none
// Sobel 3x3 edge magnitude on an RGB raster stream, zero border, per-channel
// round(sqrt(Gx^2+Gy^2)) saturated at 255. After reset the block sweeps its row
// store, clearing every column, before taking the first pixel. A pixel that yields
// no result is fetched and updates the window; one that yields a result then goes
// through squaring, 12 steps of the per-channel bit-serial square root and rounding,
// plus any wait on out_ready. The result for pixel (r,c) leaves on the transaction
// of pixel (r+1,c+1), or of pixel (r+2,0) when c is the last column; after a frame
// send image_width+1 pad ticks (command=1). Configure only while idle.
module sobel_edge_magnitude_rgb
#(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [sem_pkg::PIX_W-1:0]      red_in,
    input  wire logic [sem_pkg::PIX_W-1:0]      green_in,
    input  wire logic [sem_pkg::PIX_W-1:0]      blue_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sem_pkg::PIX_W-1:0]           red_edge,
    output logic [sem_pkg::PIX_W-1:0]           green_edge,
    output logic [sem_pkg::PIX_W-1:0]           blue_edge,
    output logic                                frame_end
);

    sem_pkg::cmd_t cmd;
    sem_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    sem_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sem_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .red_edge   (red_edge),
        .green_edge (green_edge),
        .blue_edge  (blue_edge),
        .frame_end  (frame_end)
    );

endmodule
`default_nettype wire
